// ===== rtl/core/slcfrx_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths and constants for the sync/length/checksum frame receiver.
// No dependencies.
package slcfrx_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 6;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h5A;
  localparam logic [CNT_W-1:0]  MIN_LEN   = 7'd2;
  localparam logic [CNT_W-1:0]  HDR_LEN   = 7'd2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;

endpackage

// ===== rtl/core/sync_length_checksum_frame_rx.sv =====
`timescale 1ns / 1ps
// Frame receiver: 0x5A 0x5A sync hunt, clamped length, 8-bit sum check, payload replay.
// Depends on slcfrx_pkg; frame bytes live in one single-port-read frame memory.
// An empty payload loads its result into the output register when the checksum byte is
// accepted; otherwise each payload byte goes through ST_RD (memory read), then ST_WAIT
// (output load once free). Throughput: one request per cycle while receiving, but the
// checksum byte waits for a free output and a replay blocks input until it finishes.
// Synchronous active-low reset returns to the sync hunt, output empty.
module sync_length_checksum_frame_rx #(
  parameter int FRAME_MAX = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  slcfrx_pkg::byte_t         in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output slcfrx_pkg::byte_t         out_command,
  output slcfrx_pkg::byte_t         out_payload_byte,
  output slcfrx_pkg::idx_t          out_byte_index,
  output slcfrx_pkg::idx_t          out_payload_len,
  output logic                      out_has_byte,
  output logic                      out_last
);
  import slcfrx_pkg::*;

  localparam int AW = $clog2(FRAME_MAX);

  localparam logic [1:0] PH_SYNC = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_SUM  = 2'd3;

  localparam logic [1:0] ST_RX   = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic       sync_seen_r, sync_seen_nxt;
  cnt_t       byte_count_r, byte_count_nxt;
  cnt_t       frame_length_r, frame_length_nxt;
  byte_t      sum_r, sum_nxt;
  byte_t      cmd_r, cmd_nxt;
  logic [1:0] st_r, st_nxt;
  idx_t       idx_r, idx_nxt;

  logic       out_valid_r, out_valid_nxt;
  byte_t      out_command_r, out_command_nxt;
  byte_t      out_byte_r, out_byte_nxt;
  idx_t       out_index_r, out_index_nxt;
  idx_t       out_plen_r, out_plen_nxt;
  logic       out_has_r, out_has_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_load;

  byte_t      mem [FRAME_MAX];
  logic       wr_en;
  logic [AW-1:0] wr_addr;
  byte_t      wr_data;
  logic       rd_en;
  logic [AW-1:0] rd_addr;
  byte_t      rd_data_r;

  logic       in_fire;
  logic       out_free;
  cnt_t       len_c;
  cnt_t       cnt_inc;
  idx_t       plen;
  cnt_t       frame_max_c;

  assign frame_max_c = CNT_W'(FRAME_MAX);
  assign out_free    = !out_valid_r || out_ready;
  assign in_ready    = (st_r == ST_RX) && ((phase_r != PH_SUM) || out_free);
  assign in_fire     = in_valid && in_ready;
  assign len_c       = (in_rx_byte > BYTE_W'(FRAME_MAX)) ? frame_max_c : in_rx_byte[CNT_W-1:0];
  assign cnt_inc     = byte_count_r + 1'b1;
  assign plen        = IDX_W'(frame_length_r - HDR_LEN);
  assign rd_addr     = AW'(idx_r) + AW'(2);

  always_comb begin
    phase_nxt        = phase_r;
    sync_seen_nxt    = sync_seen_r;
    byte_count_nxt   = byte_count_r;
    frame_length_nxt = frame_length_r;
    sum_nxt          = sum_r;
    cmd_nxt          = cmd_r;
    st_nxt           = st_r;
    idx_nxt          = idx_r;
    wr_en            = 1'b0;
    wr_addr          = '0;
    wr_data          = in_rx_byte;
    rd_en            = 1'b0;
    out_load         = 1'b0;
    out_command_nxt  = out_command_r;
    out_byte_nxt     = out_byte_r;
    out_index_nxt    = out_index_r;
    out_plen_nxt     = out_plen_r;
    out_has_nxt      = out_has_r;
    out_last_nxt     = out_last_r;

    unique case (st_r)
      ST_RX: begin
        if (in_fire) begin
          unique case (phase_r)
            PH_SYNC: begin
              if (in_rx_byte == SYNC_BYTE) begin
                if (sync_seen_r) begin
                  sync_seen_nxt  = 1'b0;
                  byte_count_nxt = '0;
                  sum_nxt        = '0;
                  phase_nxt      = PH_LEN;
                end else begin
                  sync_seen_nxt = 1'b1;
                end
              end else begin
                sync_seen_nxt = 1'b0;
              end
            end
            PH_LEN: begin
              if (len_c < MIN_LEN) begin
                phase_nxt      = PH_SYNC;
                sync_seen_nxt  = 1'b0;
                byte_count_nxt = '0;
              end else begin
                frame_length_nxt = len_c;
                wr_en            = 1'b1;
                wr_addr          = '0;
                wr_data          = BYTE_W'(len_c);
                byte_count_nxt   = CNT_W'(1);
                sum_nxt          = BYTE_W'(len_c);
                phase_nxt        = PH_DATA;
              end
            end
            PH_DATA: begin
              if (byte_count_r < frame_length_r) begin
                wr_en          = 1'b1;
                wr_addr        = byte_count_r[AW-1:0];
                byte_count_nxt = cnt_inc;
                sum_nxt        = sum_r + in_rx_byte;
                if (byte_count_r == CNT_W'(1)) begin
                  cmd_nxt = in_rx_byte;
                end
              end
              if (byte_count_nxt == frame_length_r) begin
                phase_nxt = PH_SUM;
              end
            end
            PH_SUM: begin
              if (sum_r == in_rx_byte) begin
                if (plen == '0) begin
                  out_load        = 1'b1;
                  out_command_nxt = cmd_r;
                  out_byte_nxt    = '0;
                  out_index_nxt   = '0;
                  out_plen_nxt    = '0;
                  out_has_nxt     = 1'b0;
                  out_last_nxt    = 1'b1;
                end else begin
                  idx_nxt = '0;
                  st_nxt  = ST_RD;
                end
              end
              phase_nxt      = PH_SYNC;
              sync_seen_nxt  = 1'b0;
              byte_count_nxt = '0;
            end
            default: phase_nxt = PH_SYNC;
          endcase
        end
      end
      ST_RD: begin
        rd_en  = 1'b1;
        st_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_command_nxt = cmd_r;
          out_byte_nxt    = rd_data_r;
          out_index_nxt   = idx_r;
          out_plen_nxt    = plen;
          out_has_nxt     = 1'b1;
          out_last_nxt    = (idx_r + 1'b1) == plen;
          if ((idx_r + 1'b1) == plen) begin
            st_nxt = ST_RX;
          end else begin
            idx_nxt = idx_r + 1'b1;
            st_nxt  = ST_RD;
          end
        end
      end
      default: st_nxt = ST_RX;
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_SYNC;
      sync_seen_r    <= 1'b0;
      byte_count_r   <= '0;
      frame_length_r <= '0;
      sum_r          <= '0;
      st_r           <= ST_RX;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      sync_seen_r    <= sync_seen_nxt;
      byte_count_r   <= byte_count_nxt;
      frame_length_r <= frame_length_nxt;
      sum_r          <= sum_nxt;
      st_r           <= st_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    idx_r         <= idx_nxt;
    out_command_r <= out_command_nxt;
    out_byte_r    <= out_byte_nxt;
    out_index_r   <= out_index_nxt;
    out_plen_r    <= out_plen_nxt;
    out_has_r     <= out_has_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_command      = out_command_r;
  assign out_payload_byte = out_byte_r;
  assign out_byte_index   = out_index_r;
  assign out_payload_len  = out_plen_r;
  assign out_has_byte     = out_has_r;
  assign out_last         = out_last_r;

endmodule

// ===== rtl/core/slcfrx_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the frame receiver's result channel, bound into the receiver module.
// Depends on slcfrx_pkg and sync_length_checksum_frame_rx.
module slcfrx_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input slcfrx_pkg::byte_t   out_command,
  input slcfrx_pkg::byte_t   out_payload_byte,
  input slcfrx_pkg::idx_t    out_byte_index,
  input slcfrx_pkg::idx_t    out_payload_len,
  input logic                out_has_byte,
  input logic                out_last
);
  import slcfrx_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command) &&
      $stable(out_payload_byte) && $stable(out_byte_index) && $stable(out_last))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_last && out_payload_len == '0 &&
      out_byte_index == '0 && out_payload_byte == '0)
    else $error("malformed empty-payload result");

  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_byte |-> out_byte_index < out_payload_len)
    else $error("payload index out of range");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_byte |->
      (out_last == ((out_byte_index + 1'b1) == out_payload_len)))
    else $error("last flag mismatch");

  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_has_byte && !out_last ##1 out_valid |->
      out_has_byte && out_byte_index == $past(out_byte_index) + 1'b1 &&
      out_command == $past(out_command))
    else $error("payload results out of order");

endmodule

bind sync_length_checksum_frame_rx slcfrx_checker u_slcfrx_checker (.*);
